// ===== rtl/mrmix_pkg.sv =====
// ----------------------------------------------------------------------------
// mrmix_pkg
// Shared constants and controller-to-datapath command type for the mixer.
// ----------------------------------------------------------------------------
package mrmix_pkg;

    localparam int MOTORS    = 4;
    localparam int AXES      = 6;
    localparam int TBL_DEPTH = MOTORS * AXES;
    localparam int TBL_AW    = 5;
    localparam int MOTOR_W   = $clog2(MOTORS);
    localparam int CNT_W     = 3;
    localparam int SQRT_CYC  = 8;

    // axis codes
    localparam logic [2:0] AX_ROLL  = 3'd3;
    localparam logic [2:0] AX_PITCH = 3'd4;
    localparam logic [2:0] AX_YAW   = 3'd5;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_RECIP = 2'd0;
    localparam logic [1:0] CFG_LIMIT = 2'd1;
    localparam logic [1:0] CFG_ATT   = 2'd2;
    localparam logic [1:0] CFG_YAW   = 2'd3;

    localparam logic [30:0] RST_RECIP = 31'd6553600;
    localparam logic [15:0] RST_LIMIT = 16'd19661;
    localparam logic [30:0] RST_ATT   = 31'd65536;
    localparam logic [30:0] RST_YAW   = 31'd65536;

    // shared multiplier operand select
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ATT,
        MUL_YAW,
        MUL_MAC,
        MUL_THR
    } t_mul_sel;

    typedef struct packed {
        logic               load_u;
        logic               mem_we;
        logic               mem_re;
        logic [TBL_AW-1:0]  mem_addr;
        t_mul_sel           mul_sel;
        logic [2:0]         axis;
        logic               w_en;
        logic [2:0]         w_axis;
        logic               acc_clr;
        logic               acc_en;
        logic               sq_start;
        logic               sq_step;
        logic               res_en;
        logic [MOTOR_W-1:0] motor;
        logic               out_load;
    } t_cmd;

endpackage

// ===== rtl/mrmix_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrmix_ctrl
// Sequencer: table load, weighting, per-motor MAC, thrust scaling, square root, result, output.
// ----------------------------------------------------------------------------
module mrmix_ctrl
    import mrmix_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    input  logic [4:0]        i_coef_index,
    input  logic              i_stall,
    output logic              o_stall,
    output logic              o_valid,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WEIGH,
        S_MAC,
        S_TMUL,
        S_TCHK,
        S_SQRT,
        S_RES,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [MOTOR_W-1:0] r_motor, n_motor;
    logic               r_valid, n_valid;
    logic               accept;
    logic               out_free;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;

    // command decode and next state
    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_motor  = r_motor;
        n_valid  = r_valid && i_stall;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.motor    = r_motor;
        o_cmd.mem_addr = TBL_AW'(r_motor) * TBL_AW'(AXES) + TBL_AW'(r_cnt);
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_action) begin
                    o_cmd.mem_we = (i_coef_index < TBL_AW'(TBL_DEPTH));
                end
                if (accept && i_action) begin
                    o_cmd.load_u = 1'b1;
                    n_state = S_WEIGH;
                    n_cnt   = '0;
                end
            end
            // roll, pitch, yaw by attitude weight, then yaw by yaw weight
            S_WEIGH: begin
                case (r_cnt)
                    3'd0: begin
                        o_cmd.mul_sel = MUL_ATT;
                        o_cmd.axis    = AX_ROLL;
                    end
                    3'd1: begin
                        o_cmd.w_en    = 1'b1;
                        o_cmd.w_axis  = AX_ROLL;
                        o_cmd.mul_sel = MUL_ATT;
                        o_cmd.axis    = AX_PITCH;
                    end
                    3'd2: begin
                        o_cmd.w_en    = 1'b1;
                        o_cmd.w_axis  = AX_PITCH;
                        o_cmd.mul_sel = MUL_ATT;
                        o_cmd.axis    = AX_YAW;
                    end
                    3'd3: begin
                        o_cmd.w_en   = 1'b1;
                        o_cmd.w_axis = AX_YAW;
                    end
                    3'd4: begin
                        o_cmd.mul_sel = MUL_YAW;
                        o_cmd.axis    = AX_YAW;
                    end
                    default: begin
                        o_cmd.w_en   = 1'b1;
                        o_cmd.w_axis = AX_YAW;
                    end
                endcase
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd5) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                    n_motor = '0;
                end
            end
            // read, multiply, accumulate overlapped over the six table entries of the motor
            S_MAC: begin
                o_cmd.acc_clr = (r_cnt == 3'd0);
                o_cmd.mem_re  = (r_cnt < 3'(AXES));
                if (r_cnt >= 3'd1 && r_cnt <= 3'(AXES)) begin
                    o_cmd.mul_sel = MUL_MAC;
                end
                o_cmd.axis   = r_cnt - 1'b1;
                o_cmd.acc_en = (r_cnt >= 3'd2);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd7) begin
                    n_state = S_TMUL;
                end
            end
            S_TMUL: begin
                o_cmd.mul_sel = MUL_THR;
                n_state = S_TCHK;
            end
            S_TCHK: begin
                o_cmd.sq_start = 1'b1;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'(SQRT_CYC - 1)) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                o_cmd.res_en = 1'b1;
                n_cnt = '0;
                if (r_motor == MOTOR_W'(MOTORS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_motor = r_motor + 1'b1;
                    n_state = S_MAC;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_motor <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_motor <= n_motor;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== rtl/mrmix_dp.sv =====
// ----------------------------------------------------------------------------
// mrmix_dp
// Datapath: mixing table, shared multiplier, accumulator, square root unit.
// ----------------------------------------------------------------------------
module mrmix_dp
    import mrmix_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic [4:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    input  logic signed [31:0] i_moment_roll,
    input  logic signed [31:0] i_moment_pitch,
    input  logic signed [31:0] i_moment_yaw,
    output logic [15:0]        o_throttle_0,
    output logic [15:0]        o_throttle_1,
    output logic [15:0]        o_throttle_2,
    output logic [15:0]        o_throttle_3,
    output logic [3:0]         o_limit_mask
);

    logic [30:0]        r_recip;
    logic [15:0]        r_limit;
    logic [30:0]        r_att;
    logic [30:0]        r_yaw;

    logic [31:0]        r_tbl [TBL_DEPTH];
    logic signed [31:0] r_coef;
    logic signed [31:0] r_u [AXES];
    logic signed [65:0] r_prod;
    logic signed [51:0] r_acc;

    logic [31:0]        r_rad;
    logic [19:0]        r_rem;
    logic [15:0]        r_root;
    logic               r_pos;
    logic               r_big;
    logic [15:0]        r_thr [MOTORS];
    logic [MOTORS-1:0]  r_mask;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] shifted;
    logic signed [31:0] w_sat;
    logic [19:0]        rem_mid, rem_nxt;
    logic [15:0]        root_mid, root_nxt;
    logic [15:0]        thr_val;
    logic               thr_clamp;

    // one restoring square root step: two radicand bits in, one root bit out
    function automatic logic [35:0] sqrt_bit(input logic [19:0] rem,
                                             input logic [15:0] root,
                                             input logic [1:0]  bits);
        logic [19:0] ext;
        logic [19:0] trial;
        ext   = {rem[17:0], bits};
        trial = {2'b00, root, 2'b01};
        if (ext >= trial) begin
            return {ext - trial, root[14:0], 1'b1};
        end
        return {ext, root[14:0], 1'b0};
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip <= RST_RECIP;
            r_limit <= RST_LIMIT;
            r_att   <= RST_ATT;
            r_yaw   <= RST_YAW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RECIP: r_recip <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                CFG_ATT:   r_att   <= i_cfg_data;
                CFG_YAW:   r_yaw   <= i_cfg_data;
                default:   r_yaw   <= r_yaw;
            endcase
        end
    end

    // mixing table, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_tbl[i_coef_index] <= i_coef_value;
        end
        if (i_cmd.mem_re) begin
            r_coef <= r_tbl[i_cmd.mem_addr];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_ATT: begin
                mul_a = 33'(r_u[i_cmd.axis]);
                mul_b = {2'b00, r_att};
            end
            MUL_YAW: begin
                mul_a = 33'(r_u[i_cmd.axis]);
                mul_b = {2'b00, r_yaw};
            end
            MUL_MAC: begin
                mul_a = 33'(r_coef);
                mul_b = 33'(r_u[i_cmd.axis]);
            end
            MUL_THR: begin
                mul_a = {1'b0, r_acc[31:0]};
                mul_b = {2'b00, r_recip};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // floor by 2^16, then saturate to 32 bits
    assign shifted = r_prod >>> 16;
    always_comb begin
        if (!(&shifted[65:31]) && (|shifted[65:31])) begin
            w_sat = shifted[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_sat = shifted[31:0];
        end
    end

    assign {rem_mid, root_mid} = sqrt_bit(r_rem, r_root, r_rad[31:30]);
    assign {rem_nxt, root_nxt} = sqrt_bit(rem_mid, root_mid, r_rad[29:28]);

    // throttle select and clamp
    always_comb begin
        thr_val   = '0;
        thr_clamp = 1'b0;
        if (r_pos && (r_big || r_root > r_limit)) begin
            thr_val   = r_limit;
            thr_clamp = 1'b1;
        end else if (r_pos) begin
            thr_val = r_root;
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_u) begin
            r_u[0] <= i_force_x;
            r_u[1] <= i_force_y;
            r_u[2] <= i_force_z;
            r_u[3] <= i_moment_roll;
            r_u[4] <= i_moment_pitch;
            r_u[5] <= i_moment_yaw;
        end else if (i_cmd.w_en) begin
            r_u[i_cmd.w_axis] <= w_sat;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + 52'($signed(r_prod[63:16]));
        end
        if (i_cmd.sq_start) begin
            r_pos  <= (r_acc > 52'sd0) && (r_recip != '0);
            r_big  <= (r_acc[51:32] != '0) || (r_prod[63:32] != '0);
            r_rad  <= r_prod[31:0];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad  <= {r_rad[27:0], 4'b0000};
            r_rem  <= rem_nxt;
            r_root <= root_nxt;
        end
        if (i_cmd.res_en) begin
            r_thr[i_cmd.motor]  <= thr_val;
            r_mask[i_cmd.motor] <= thr_clamp;
        end
        if (i_cmd.out_load) begin
            o_throttle_0 <= r_thr[0];
            o_throttle_1 <= r_thr[1];
            o_throttle_2 <= r_thr[2];
            o_throttle_3 <= r_thr[3];
            o_limit_mask <= r_mask[3:0];
        end
    end

endmodule

// ===== rtl/multirotor_wrench_to_throttle_mixer.sv =====
// Load items are taken one per cycle while idle; a mix item holds o_stall until its
// result is loaded, so no new item is taken before the last mix item is through.
// Mix time is set by the single shared multiplier (weighting, then per motor MAC
// and thrust scaling) and the 4-bit-per-cycle root, run once per motor.
// Reset: synchronous active low; configuration returns to defaults,
// the mixing table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// multirotor_wrench_to_throttle_mixer
// Maps a 6-axis wrench to four Q0.16 motor throttles through a loaded table.
// ----------------------------------------------------------------------------
module multirotor_wrench_to_throttle_mixer
    import mrmix_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic [4:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_force_z,
    input  logic signed [31:0] i_moment_roll,
    input  logic signed [31:0] i_moment_pitch,
    input  logic signed [31:0] i_moment_yaw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_throttle_0,
    output logic [15:0]        o_throttle_1,
    output logic [15:0]        o_throttle_2,
    output logic [15:0]        o_throttle_3,
    output logic [3:0]         o_limit_mask
);

    t_cmd cmd;

    mrmix_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_action     (i_action),
        .i_coef_index (i_coef_index),
        .i_stall      (i_stall),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_cmd        (cmd)
    );

    mrmix_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .i_force_x      (i_force_x),
        .i_force_y      (i_force_y),
        .i_force_z      (i_force_z),
        .i_moment_roll  (i_moment_roll),
        .i_moment_pitch (i_moment_pitch),
        .i_moment_yaw   (i_moment_yaw),
        .o_throttle_0   (o_throttle_0),
        .o_throttle_1   (o_throttle_1),
        .o_throttle_2   (o_throttle_2),
        .o_throttle_3   (o_throttle_3),
        .o_limit_mask   (o_limit_mask)
    );

endmodule

// ===== rtl/mrmix_checker.sv =====
// ----------------------------------------------------------------------------
// mrmix_checker
// Port-level checks on the mixer handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module mrmix_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic i_action,
    input logic o_valid,
    input logic i_stall
);

    // result waits while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a mix item keeps the input side busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_action |=> o_stall)
        else $error("input ready right after mix item");

    // a mix item's result does not rise in the cycle after acceptance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_action |=> !$rose(o_valid))
        else $error("result too early");

    // a load item leaves the block ready
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_action |=> !o_stall)
        else $error("load item stalled input");

    // reset empties the output
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind multirotor_wrench_to_throttle_mixer mrmix_checker u_mrmix_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_action (i_action),
    .o_valid  (o_valid),
    .i_stall  (i_stall)
);
